@@ rtl/dsf_pkg.sv @@
// Shared types, constants and helpers for the damped spring force pipeline.
package dsf_pkg;

    localparam int unsigned LANES  = 3;
    localparam int unsigned SMAG_W = 97;

    typedef struct packed {
        logic signed [31:0] dpos_x;
        logic signed [31:0] dpos_y;
        logic signed [31:0] dpos_z;
        logic signed [31:0] dvel_x;
        logic signed [31:0] dvel_y;
        logic signed [31:0] dvel_z;
        logic [30:0]        rest_len;
        logic [31:0]        stiffness;
        logic [31:0]        damping;
    } spring_in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               degenerate;
    } spring_out_t;

    // Geometry after the front end: magnitudes, signs and the two dot sums
    typedef struct packed {
        logic [LANES-1:0][31:0] pmag;
        logic [LANES-1:0]       pneg;
        logic [30:0]            len;
        logic [31:0]            k;
        logic [31:0]            c;
        logic                   dneg;
        logic [63:0]            dmag;
        logic [63:0]            s2;
        logic                   deg;
    } geom_t;

    // Scalar force term and per-axis data for the divide lanes
    typedef struct packed {
        logic [SMAG_W-1:0]      smag;
        logic [LANES-1:0]       fneg;
        logic [LANES-1:0][31:0] pmag;
        logic [63:0]            s2;
        logic                   deg;
    } term_t;

    // Magnitude of a 32 bit two's complement value (most negative maps to 2^31)
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

@@ rtl/damped_spring_force.sv @@
// Throughput: one spring per cycle while the output is not stalled.
// A 32 stage root and a 32 stage divide set the pipeline depth.
// A stalled output freezes the whole pipeline; one more input is held in a skid register.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers are not reset.
// Top level: damped spring force pipeline.
module damped_spring_force
    import dsf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spring_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output spring_out_t out_data
);

    logic        en;
    logic        acc;
    logic        skid_vld_reg;
    spring_in_t  skid_reg;
    logic        front_valid;
    spring_in_t  front_data;

    logic        prep_valid, sqrt_valid, term_valid;
    geom_t       prep_data, sqrt_data;
    logic [31:0] sqrt_root;
    term_t       term_data;

    // Advance the pipeline unless a finished result is held
    assign en  = !out_valid || out_ready;
    assign acc = in_valid && in_ready;

    // Skid register takes one transfer while stalled
    assign in_ready    = !skid_vld_reg;
    assign front_valid = skid_vld_reg || acc;
    assign front_data  = skid_vld_reg ? skid_reg : in_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (en)
            skid_vld_reg <= 1'b0;
        else if (acc)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!en && acc)
            skid_reg <= in_data;
    end

    dsf_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    dsf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_data  (sqrt_data)
    );

    dsf_term u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_root   (sqrt_root),
        .in_data   (sqrt_data),
        .out_valid (term_valid),
        .out_data  (term_data)
    );

    dsf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (term_valid),
        .in_data   (term_data),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ rtl/dsf_prep.sv @@
// Front end: sign split, squares and products, sums, dot product sign.
module dsf_prep
    import dsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  spring_in_t in_data,
    output logic       out_valid,
    output geom_t      out_data
);

    logic [LANES-1:0][31:0] dp_w;
    logic [LANES-1:0][31:0] dv_w;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LANES-1:0][31:0] pmag1_reg, vmag1_reg, pmag2_reg, pmag3_reg;
    logic [LANES-1:0]       pneg1_reg, vneg1_reg, pneg2_reg, pneg3_reg;
    logic [30:0]            len1_reg, len2_reg, len3_reg;
    logic [31:0]            k1_reg, k2_reg, k3_reg;
    logic [31:0]            c1_reg, c2_reg, c3_reg;
    logic [LANES-1:0][63:0] sq2_reg, pv2_reg;
    logic [LANES-1:0]       xs2_reg;
    logic [63:0]            s2_3_reg, pp3_reg, pn3_reg;
    geom_t                  out_reg;
    geom_t                  out_next;
    logic [63:0]            s2_next, pp_next, pn_next;

    assign dp_w = {in_data.dpos_z, in_data.dpos_y, in_data.dpos_x};
    assign dv_w = {in_data.dvel_z, in_data.dvel_y, in_data.dvel_x};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Sum squares and split the dot product by sign
    always_comb
    begin
        s2_next = 64'd0;
        pp_next = 64'd0;
        pn_next = 64'd0;
        for (int i = 0; i < LANES; i++)
        begin
            s2_next = s2_next + sq2_reg[i];
            if (xs2_reg[i])
                pn_next = pn_next + pv2_reg[i];
            else
                pp_next = pp_next + pv2_reg[i];
        end
    end

    // Resolve the dot product sign and flag zero distance
    always_comb
    begin
        out_next.pmag = pmag3_reg;
        out_next.pneg = pneg3_reg;
        out_next.len  = len3_reg;
        out_next.k    = k3_reg;
        out_next.c    = c3_reg;
        out_next.dneg = pn3_reg > pp3_reg;
        out_next.dmag = (pn3_reg > pp3_reg) ? (pn3_reg - pp3_reg) : (pp3_reg - pn3_reg);
        out_next.s2   = s2_3_reg;
        out_next.deg  = (s2_3_reg == 64'd0);
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pmag1_reg[i] <= mag32(dp_w[i]);
                pneg1_reg[i] <= dp_w[i][31];
                vmag1_reg[i] <= mag32(dv_w[i]);
                vneg1_reg[i] <= dv_w[i][31];
                sq2_reg[i]   <= pmag1_reg[i] * pmag1_reg[i];
                pv2_reg[i]   <= pmag1_reg[i] * vmag1_reg[i];
                xs2_reg[i]   <= pneg1_reg[i] ^ vneg1_reg[i];
            end
            len1_reg  <= in_data.rest_len;
            k1_reg    <= in_data.stiffness;
            c1_reg    <= in_data.damping;
            pmag2_reg <= pmag1_reg;
            pneg2_reg <= pneg1_reg;
            len2_reg  <= len1_reg;
            k2_reg    <= k1_reg;
            c2_reg    <= c1_reg;
            s2_3_reg  <= s2_next;
            pp3_reg   <= pp_next;
            pn3_reg   <= pn_next;
            pmag3_reg <= pmag2_reg;
            pneg3_reg <= pneg2_reg;
            len3_reg  <= len2_reg;
            k3_reg    <= k2_reg;
            c3_reg    <= c2_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/dsf_sqrt.sv @@
// Integer square root of the squared distance, one result bit per stage.
module dsf_sqrt
    import dsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  geom_t       in_data,
    output logic        out_valid,
    output logic [31:0] out_root,
    output geom_t       out_data
);

    localparam int unsigned STEPS = 32;

    logic [63:0] rem_reg  [0:STEPS-1];
    logic [63:0] root_reg [0:STEPS-1];
    geom_t       side_reg [0:STEPS-1];
    logic        vld_reg  [0:STEPS-1];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        logic [63:0] rem_cur, root_cur, trial;
        logic [63:0] rem_next, root_next;
        geom_t       side_cur;
        logic        vld_cur;

        if (j == 0)
        begin : g_first
            assign rem_cur  = in_data.s2;
            assign root_cur = 64'd0;
            assign side_cur = in_data;
            assign vld_cur  = in_valid;
        end
        else
        begin : g_next
            assign rem_cur  = rem_reg[j-1];
            assign root_cur = root_reg[j-1];
            assign side_cur = side_reg[j-1];
            assign vld_cur  = vld_reg[j-1];
        end

        // Try this root bit and keep it when the remainder allows
        always_comb
        begin
            trial = root_cur + BIT;
            if (rem_cur >= trial)
            begin
                rem_next  = rem_cur - trial;
                root_next = (root_cur >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = root_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1][31:0];
    assign out_data  = side_reg[STEPS-1];

endmodule

@@ rtl/dsf_term.sv @@
// Scalar force term S = k*(d-L)*d + c*p in sign and magnitude.
module dsf_term
    import dsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_root,
    input  geom_t       in_data,
    output logic        out_valid,
    output term_t       out_data
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    geom_t       g1_reg, g2_reg, g3_reg, g4_reg;
    logic [31:0] d1_reg, d2_reg;
    logic        eneg1_reg, eneg2_reg, eneg3_reg, eneg4_reg;
    logic [31:0] emag1_reg;
    logic [63:0] bp0_reg, bp1_reg;
    logic [63:0] ke2_reg;
    logic [95:0] bmag2_reg, bmag3_reg, bmag4_reg;
    logic [63:0] ap0_reg, ap1_reg;
    logic [95:0] amag4_reg;
    term_t       out_reg;

    logic [31:0]       len_ext;
    logic              eneg_w;
    logic [31:0]       emag_w;
    logic [SMAG_W-1:0] sum_w, dab_w, dba_w;
    logic              sneg_w;
    term_t             out_next;

    // Spring extension d - L
    assign len_ext = {1'b0, in_data.len};
    assign eneg_w  = in_root < len_ext;
    assign emag_w  = eneg_w ? (len_ext - in_root) : (in_root - len_ext);

    // Combine spring and damper terms by sign
    always_comb
    begin
        sum_w = {1'b0, amag4_reg} + {1'b0, bmag4_reg};
        dab_w = {1'b0, amag4_reg} - {1'b0, bmag4_reg};
        dba_w = {1'b0, bmag4_reg} - {1'b0, amag4_reg};
        if (eneg4_reg == g4_reg.dneg)
        begin
            out_next.smag = sum_w;
            sneg_w        = eneg4_reg;
        end
        else if (amag4_reg >= bmag4_reg)
        begin
            out_next.smag = dab_w;
            sneg_w        = eneg4_reg;
        end
        else
        begin
            out_next.smag = dba_w;
            sneg_w        = g4_reg.dneg;
        end
        if (g4_reg.deg)
            out_next.smag = '0;
        for (int i = 0; i < LANES; i++)
            out_next.fneg[i] = ~(sneg_w ^ g4_reg.pneg[i]);
        out_next.pmag = g4_reg.pmag;
        out_next.s2   = g4_reg.s2;
        out_next.deg  = g4_reg.deg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Partial products are registered before they are summed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg    <= in_data;
            d1_reg    <= in_root;
            eneg1_reg <= eneg_w;
            emag1_reg <= emag_w;
            bp0_reg   <= in_data.c * in_data.dmag[31:0];
            bp1_reg   <= in_data.c * in_data.dmag[63:32];

            g2_reg    <= g1_reg;
            d2_reg    <= d1_reg;
            eneg2_reg <= eneg1_reg;
            ke2_reg   <= g1_reg.k * emag1_reg;
            bmag2_reg <= {32'd0, bp0_reg} + {bp1_reg, 32'd0};

            g3_reg    <= g2_reg;
            eneg3_reg <= eneg2_reg;
            bmag3_reg <= bmag2_reg;
            ap0_reg   <= ke2_reg[31:0] * d2_reg;
            ap1_reg   <= ke2_reg[63:32] * d2_reg;

            g4_reg    <= g3_reg;
            eneg4_reg <= eneg3_reg;
            bmag4_reg <= bmag3_reg;
            amag4_reg <= {32'd0, ap0_reg} + {ap1_reg, 32'd0};

            out_reg   <= out_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/dsf_div.sv @@
// Three divide lanes: S*dp_i / (s2*2^F) rounded, restoring, then saturated.
module dsf_div
    import dsf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  term_t       in_data,
    output logic        out_valid,
    output spring_out_t out_data
);

    localparam int unsigned DW    = 64 + FRAC_BITS;
    localparam int unsigned STEPS = 32;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic [LANES-1:0][63:0]  pp0_reg, pp1_reg, pp2_reg;
    logic [LANES-1:0][31:0]  pp3_reg;
    logic [LANES-1:0][127:0] prod_reg, num_reg;
    logic [DW-1:0]           den1_reg, den2_reg, den3_reg, den4_reg;
    logic [LANES-1:0]        fneg1_reg, fneg2_reg, fneg3_reg, fneg4_reg;
    logic                    deg1_reg, deg2_reg, deg3_reg, deg4_reg;
    logic [LANES-1:0][DW-1:0] rem4_reg;
    logic [LANES-1:0][31:0]  lq4_reg;
    logic [LANES-1:0]        ov4_reg;

    logic [LANES-1:0][DW-1:0] rem_reg  [0:STEPS-1];
    logic [LANES-1:0][31:0]   lq_reg   [0:STEPS-1];
    logic [LANES-1:0]         ov_reg   [0:STEPS-1];
    logic [LANES-1:0]         fneg_reg [0:STEPS-1];
    logic [DW-1:0]            den_reg  [0:STEPS-1];
    logic                     deg_reg  [0:STEPS-1];
    logic                     vld_reg  [0:STEPS-1];

    spring_out_t             out_reg;
    logic [DW-1:0]           den_w;
    logic [LANES-1:0][31:0]  force_w;

    // Divisor is s2 scaled by 2^F; one for zero distance keeps the lanes at zero
    assign den_w = in_data.deg ? DW'(1) : (DW'(in_data.s2) << FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Multiply, sum, add half divisor, split off the high part
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pp0_reg[i]  <= in_data.smag[31:0] * in_data.pmag[i];
                pp1_reg[i]  <= in_data.smag[63:32] * in_data.pmag[i];
                pp2_reg[i]  <= in_data.smag[95:64] * in_data.pmag[i];
                pp3_reg[i]  <= in_data.smag[96] ? in_data.pmag[i] : 32'd0;
                prod_reg[i] <= {pp2_reg[i], pp0_reg[i]} + {pp3_reg[i], pp1_reg[i], 32'd0};
                num_reg[i]  <= prod_reg[i] + 128'(den2_reg >> 1);
                ov4_reg[i]  <= num_reg[i][127:32] >= 96'(den3_reg);
                rem4_reg[i] <= num_reg[i][DW+31:32];
                lq4_reg[i]  <= num_reg[i][31:0];
            end
            den1_reg  <= den_w;
            den2_reg  <= den1_reg;
            den3_reg  <= den2_reg;
            den4_reg  <= den3_reg;
            fneg1_reg <= in_data.fneg;
            fneg2_reg <= fneg1_reg;
            fneg3_reg <= fneg2_reg;
            fneg4_reg <= fneg3_reg;
            deg1_reg  <= in_data.deg;
            deg2_reg  <= deg1_reg;
            deg3_reg  <= deg2_reg;
            deg4_reg  <= deg3_reg;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic [LANES-1:0][DW-1:0] rem_cur, rem_next;
        logic [LANES-1:0][31:0]   lq_cur, lq_next;
        logic [LANES-1:0]         ov_cur, fneg_cur;
        logic [DW-1:0]            den_cur;
        logic                     deg_cur, vld_cur;

        if (j == 0)
        begin : g_first
            assign rem_cur  = rem4_reg;
            assign lq_cur   = lq4_reg;
            assign ov_cur   = ov4_reg;
            assign fneg_cur = fneg4_reg;
            assign den_cur  = den4_reg;
            assign deg_cur  = deg4_reg;
            assign vld_cur  = v4_reg;
        end
        else
        begin : g_next
            assign rem_cur  = rem_reg[j-1];
            assign lq_cur   = lq_reg[j-1];
            assign ov_cur   = ov_reg[j-1];
            assign fneg_cur = fneg_reg[j-1];
            assign den_cur  = den_reg[j-1];
            assign deg_cur  = deg_reg[j-1];
            assign vld_cur  = vld_reg[j-1];
        end

        // Shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            logic [DW:0] shifted;
            logic        ge;
            for (int i = 0; i < LANES; i++)
            begin
                shifted = {rem_cur[i], lq_cur[i][31]};
                ge      = shifted >= {1'b0, den_cur};
                rem_next[i] = ge ? DW'(shifted - {1'b0, den_cur}) : DW'(shifted);
                lq_next[i]  = {lq_cur[i][30:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                lq_reg[j]   <= lq_next;
                ov_reg[j]   <= ov_cur;
                fneg_reg[j] <= fneg_cur;
                den_reg[j]  <= den_cur;
                deg_reg[j]  <= deg_cur;
            end
        end
    end

    // Apply sign and saturate to 32 bits
    always_comb
    begin
        logic [31:0] q;
        logic        ov;
        for (int i = 0; i < LANES; i++)
        begin
            q  = lq_reg[STEPS-1][i];
            ov = ov_reg[STEPS-1][i];
            if (fneg_reg[STEPS-1][i])
                force_w[i] = (ov || q[31]) ? 32'h8000_0000 : (~q + 32'd1);
            else
                force_w[i] = (ov || q[31]) ? 32'h7FFF_FFFF : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld_reg[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.force_x    <= force_w[0];
            out_reg.force_y    <= force_w[1];
            out_reg.force_z    <= force_w[2];
            out_reg.degenerate <= deg_reg[STEPS-1];
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule
